// File: hdl/gcl_pkg.sv
package gcl_pkg;

  // operand and result widths
  localparam int unsigned OpW  = 16;
  localparam int unsigned ResW = 32;
  localparam int unsigned CntW = 5;
  localparam int unsigned ShW  = 4;
  localparam int unsigned PcW  = 5;

  typedef logic [PcW-1:0] pc_t;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_SHIFT_BOTH,
    OP_SHIFT_X,
    OP_SHIFT_Y,
    OP_SUB,
    OP_G_SHL,
    OP_G_X,
    OP_G_Y,
    OP_RES_G,
    OP_RES_ZERO,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL,
    OP_HALT
  } dp_op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_X_ZERO,
    C_Y_ZERO,
    C_NOT_BOTH_EVEN,
    C_X_ODD,
    C_Y_ODD,
    C_Y_NZ,
    C_OP_LCM,
    C_CNT_MORE
  } jmp_cond_e;

  typedef struct packed {
    dp_op_e    op;
    jmp_cond_e cond;
    pc_t       target;
  } uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic both_even;
    logic x_odd;
    logic y_odd;
    logic y_nz;
    logic op_lcm;
    logic cnt_more;
  } dp_flags_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic busy;
    logic fire;
  } seq_stat_t;

  typedef struct packed {
    logic           op;
    logic [OpW-1:0] a;
    logic [OpW-1:0] b;
  } in_item_t;

  typedef struct packed {
    logic [ResW-1:0] value;
  } out_item_t;

  // program labels
  localparam pc_t LBothEven = pc_t'(2);
  localparam pc_t LXOdd     = pc_t'(4);
  localparam pc_t LYOdd     = pc_t'(6);
  localparam pc_t LSub      = pc_t'(10);
  localparam pc_t LLcm      = pc_t'(11);
  localparam pc_t LDiv      = pc_t'(12);
  localparam pc_t LGy       = pc_t'(14);
  localparam pc_t LGx       = pc_t'(15);
  localparam pc_t LZeroSel  = pc_t'(16);
  localparam pc_t LZeroRes  = pc_t'(18);
  localparam pc_t LHalt     = pc_t'(19);

  // microprogram: binary gcd, then restoring divide and multiply for lcm
  // an even y that is already zero falls out of the shift loop into step 8
  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    case (pc)
      pc_t'(0):  w = '{OP_NOP,        C_X_ZERO,        LGy};
      pc_t'(1):  w = '{OP_NOP,        C_Y_ZERO,        LGx};
      pc_t'(2):  w = '{OP_NOP,        C_NOT_BOTH_EVEN, LXOdd};
      pc_t'(3):  w = '{OP_SHIFT_BOTH, C_ALWAYS,        LBothEven};
      pc_t'(4):  w = '{OP_NOP,        C_X_ODD,         LYOdd};
      pc_t'(5):  w = '{OP_SHIFT_X,    C_ALWAYS,        LXOdd};
      pc_t'(6):  w = '{OP_NOP,        C_Y_ODD,         LSub};
      pc_t'(7):  w = '{OP_SHIFT_Y,    C_Y_NZ,          LYOdd};
      pc_t'(8):  w = '{OP_G_SHL,      C_OP_LCM,        LLcm};
      pc_t'(9):  w = '{OP_RES_G,      C_ALWAYS,        LHalt};
      pc_t'(10): w = '{OP_SUB,        C_ALWAYS,        LYOdd};
      pc_t'(11): w = '{OP_DIV_INIT,   C_NEVER,         LDiv};
      pc_t'(12): w = '{OP_DIV_STEP,   C_CNT_MORE,      LDiv};
      pc_t'(13): w = '{OP_MUL,        C_ALWAYS,        LHalt};
      pc_t'(14): w = '{OP_G_Y,        C_ALWAYS,        LZeroSel};
      pc_t'(15): w = '{OP_G_X,        C_NEVER,         LZeroSel};
      pc_t'(16): w = '{OP_NOP,        C_OP_LCM,        LZeroRes};
      pc_t'(17): w = '{OP_RES_G,      C_ALWAYS,        LHalt};
      pc_t'(18): w = '{OP_RES_ZERO,   C_NEVER,         LHalt};
      pc_t'(19): w = '{OP_HALT,       C_NEVER,         LHalt};
      default:   w = '{OP_HALT,       C_NEVER,         LHalt};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/gcl_stream_if.sv
interface gcl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/gcl_datapath.sv
module gcl_datapath (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  gcl_pkg::in_item_t    item_i,
  input  gcl_pkg::dp_op_e      op_i,
  output gcl_pkg::dp_flags_t   flags_o,
  output logic [31:0]          res_o
);
  import gcl_pkg::*;

  logic [OpW-1:0]  x_q, x_d, y_q, y_d, g_q, g_d, r_q, r_d, q_q, q_d;
  logic [OpW-1:0]  a_q, b_q;
  logic            op_q;
  logic [ShW-1:0]  k_q, k_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ResW-1:0] res_q, res_d;

  // divider trial subtract
  logic [OpW:0]    trial;
  logic [OpW:0]    trial_diff;
  logic            trial_ok;

  assign trial      = {r_q, q_q[OpW-1]};
  assign trial_diff = trial - {1'b0, g_q};
  assign trial_ok   = trial >= {1'b0, g_q};

  // operation decode
  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    g_d   = g_q;
    r_d   = r_q;
    q_d   = q_q;
    k_d   = k_q;
    cnt_d = cnt_q;
    res_d = res_q;
    case (op_i)
      OP_SHIFT_BOTH: begin
        x_d = x_q >> 1;
        y_d = y_q >> 1;
        k_d = k_q + ShW'(1);
      end
      OP_SHIFT_X: x_d = x_q >> 1;
      OP_SHIFT_Y: y_d = y_q >> 1;
      OP_SUB: begin
        if (x_q > y_q) begin
          x_d = y_q;
          y_d = x_q - y_q;
        end else begin
          y_d = y_q - x_q;
        end
      end
      OP_G_SHL:    g_d = x_q << k_q;
      OP_G_X:      g_d = x_q;
      OP_G_Y:      g_d = y_q;
      OP_RES_G:    res_d = {{(ResW-OpW){1'b0}}, g_q};
      OP_RES_ZERO: res_d = '0;
      OP_DIV_INIT: begin
        r_d   = '0;
        q_d   = a_q;
        cnt_d = CntW'(OpW);
      end
      OP_DIV_STEP: begin
        r_d   = trial_ok ? trial_diff[OpW-1:0] : trial[OpW-1:0];
        q_d   = {q_q[OpW-2:0], trial_ok};
        cnt_d = cnt_q - CntW'(1);
      end
      OP_MUL:  res_d = ResW'(q_q) * ResW'(b_q);
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q  <= item_i.a;
      y_q  <= item_i.b;
      a_q  <= item_i.a;
      b_q  <= item_i.b;
      op_q <= item_i.op;
      k_q  <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      k_q <= k_d;
    end
    g_q   <= g_d;
    r_q   <= r_d;
    q_q   <= q_d;
    cnt_q <= cnt_d;
    res_q <= res_d;
  end

  // status flags
  assign flags_o.x_zero    = (x_q == '0);
  assign flags_o.y_zero    = (y_q == '0);
  assign flags_o.both_even = ~x_q[0] & ~y_q[0];
  assign flags_o.x_odd     = x_q[0];
  assign flags_o.y_odd     = y_q[0];
  assign flags_o.y_nz      = (y_q != '0);
  assign flags_o.op_lcm    = op_q;
  assign flags_o.cnt_more  = (cnt_q != CntW'(1));

  assign res_o = res_q;

endmodule

// File: hdl/gcl_seq.sv
module gcl_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 out_free_i,
  input  gcl_pkg::dp_flags_t   flags_i,
  output gcl_pkg::dp_op_e      op_o,
  output gcl_pkg::seq_stat_t   stat_o
);
  import gcl_pkg::*;

  pc_t    pc_q, pc_d;
  logic   busy_q, busy_d;
  uword_t uw;
  logic   taken;
  logic   fire;

  assign uw = ucode_rom(pc_q);

  // jump condition select
  always_comb begin
    case (uw.cond)
      C_ALWAYS:        taken = 1'b1;
      C_X_ZERO:        taken = flags_i.x_zero;
      C_Y_ZERO:        taken = flags_i.y_zero;
      C_NOT_BOTH_EVEN: taken = ~flags_i.both_even;
      C_X_ODD:         taken = flags_i.x_odd;
      C_Y_ODD:         taken = flags_i.y_odd;
      C_Y_NZ:          taken = flags_i.y_nz;
      C_OP_LCM:        taken = flags_i.op_lcm;
      C_CNT_MORE:      taken = flags_i.cnt_more;
      default:         taken = 1'b0;
    endcase
  end

  // halt hands the result over once the output slot is free
  assign fire = busy_q && (uw.op == OP_HALT) && out_free_i;

  // step counter
  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (start_i) begin
      pc_d   = '0;
      busy_d = 1'b1;
    end else if (fire) begin
      busy_d = 1'b0;
    end else if (busy_q && (uw.op != OP_HALT)) begin
      pc_d = taken ? uw.target : pc_q + pc_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

  assign op_o        = busy_q ? uw.op : OP_NOP;
  assign stat_o.busy = busy_q;
  assign stat_o.fire = fire;

endmodule

// File: hdl/gcd_lcm_unit_core.sv
// gcd / lcm unit, 16-bit unsigned operands, 32-bit unsigned result
//
// in_i carries one item {op, a, b}; op = 0 asks for the greatest common
// divisor, op = 1 for the least common multiple. out_o carries {value}.
// Both are valid/ready channels; an item moves when valid and ready are high.
//
// A small microprogram drives the datapath one step per cycle up to its halt
// step: binary gcd (shift and subtract loop), then for lcm a 16-step
// restoring divide a/g and one 16x16 multiply. When a is zero, b is taken as
// the gcd, and when only b is zero, a is; the lcm is then zero. Otherwise each
// shift and each subtract of the gcd loop is a test step and an operation
// step; a*b can be halved at most 31 times, which bounds the gcd loop.
// One item is worked on at a time; ready returns the cycle after the result
// moves to the output register.
//
// When the receiver stalls, the result waits in the output register and the
// next item can still be computed; its halt step holds until the slot frees.
// Reset clears the sequencer and the output valid; no state lives between
// items.
module gcd_lcm_unit_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  gcl_stream_if.sink   in_i,
  gcl_stream_if.source out_o
);
  import gcl_pkg::*;

  dp_op_e    op;
  dp_flags_t flags;
  seq_stat_t stat;
  logic      accept;
  logic      out_free;
  logic [ResW-1:0] res;
  logic [ResW-1:0] out_data_q;
  logic      out_vld_q;
  in_item_t  item;

  assign item.op = in_i.data.op;
  assign item.a  = in_i.data.a;
  assign item.b  = in_i.data.b;

  assign in_i.ready = ~stat.busy;
  assign accept     = in_i.valid & ~stat.busy;
  assign out_free   = ~out_vld_q | out_o.ready;

  gcl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .out_free_i (out_free),
    .flags_i    (flags),
    .op_o       (op),
    .stat_o     (stat)
  );

  gcl_datapath u_dp (
    .clk_i   (clk_i),
    .load_i  (accept),
    .item_i  (item),
    .op_i    (op),
    .flags_o (flags),
    .res_o   (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (stat.fire) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.fire) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.data.value = out_data_q;

  // an accepted item starts the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> stat.busy)
    else $error("sequencer not started by accepted item");

  // the sequencer only starts from an accepted item
  a_busy_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stat.busy) |-> $past(accept))
    else $error("sequencer started without an item");

  // a finished item lands in the output register and frees the sequencer
  a_fire_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.fire |=> (out_vld_q && !stat.busy))
    else $error("result not handed to output register");

  // the sequencer never writes a result over one still waiting in the output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.fire |-> (!out_vld_q || out_o.ready))
    else $error("output register overwritten while stalled");

endmodule
